[design/thsc_pkg.sv]
// Shared types and constants for the temperature / humidity conditioner.
// Used by the core and by its port checker; no dependencies.
package thsc_pkg;

    // Field widths and value limits
    localparam int ADC_W   = 10;
    localparam int VAL_W   = 14;
    localparam int SUM_W   = 16;
    localparam int CNT_W   = 7;
    localparam int KIND_W  = 2;
    localparam int TAG_W   = 4;

    localparam logic signed [VAL_W-1:0] VAL_MAX = 14'sd8191;
    localparam logic signed [VAL_W-1:0] VAL_MIN = -14'sd8192;
    localparam logic [VAL_W-1:0]        NEG_LIMIT = 14'h2000;

    localparam logic [CNT_W-1:0] MAX_SAMPLES = 7'd64;

    // Datapath widths, sized for the widest converter (16 bits) and 16 sensors
    localparam int ACC_W   = 56;              // signed product accumulator
    localparam int DEN_W   = 44;              // divisor
    localparam int REM_W   = 56;              // division remainder
    localparam int Q_W     = 15;              // quotient bits, top one flags overflow
    localparam int DV_W    = DEN_W + Q_W - 1; // divisor shifted to quotient MSB
    localparam int MUL_B_W = 22;              // covers 62 * (2^16 - 1)
    localparam int P_W     = 23;              // sample count times full scale
    localparam int IT_W    = 4;
    localparam int GAIN_FRAC = 14;

    // Conversion constants
    localparam int K_TEMP_DEN  = 1638400;     // 100 * 16384
    localparam int K_CENTI     = 100;
    localparam int K_HALF_DEG  = 50000;
    localparam int K_COMP_BASE = 1054600;
    localparam int K_COMP_TEMP = 216;
    localparam int K_HUM_OFS   = 1600;
    localparam int K_HUM_SPAN  = 62;
    localparam int K_E4        = 10000;
    localparam int K_E3        = 1000;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_TEMP     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TEMP_AVG = 2'd1;
    localparam logic [KIND_W-1:0] KIND_HUM      = 2'd2;
    localparam logic [KIND_W-1:0] KIND_HUM_AVG  = 2'd3;

    // Input action codes
    localparam logic ACT_TEMP = 1'b0;
    localparam logic ACT_HUM  = 1'b1;

    // Register indexes (byte address / 4)
    localparam logic [1:0] REG_SUPPLY = 2'd0;
    localparam logic [1:0] REG_SPR    = 2'd1;
    localparam logic [1:0] REG_GAIN   = 2'd2;
    localparam logic [1:0] REG_OFFSET = 2'd3;

    // Register reset values
    localparam logic [12:0]        RST_SUPPLY = 13'd5000;
    localparam logic [CNT_W-1:0]   RST_SPR    = 7'd8;
    localparam logic [15:0]        RST_GAIN   = 16'd25836;
    localparam logic signed [15:0] RST_OFFSET = -16'sd8384;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACCUM,
        ST_LOAD,
        ST_MUL,
        ST_DSET,
        ST_DIV,
        ST_EMIT
    } state_t;

    // Micro-operations of the serial multiply-accumulate sequencer
    typedef enum logic [3:0] {
        OP_T_DEN,
        OP_T_SV,
        OP_T_X100,
        OP_T_X,
        OP_T_G,
        OP_T_OFF,
        OP_H_COMP,
        OP_H_DEN,
        OP_H_DIFF,
        OP_H_E4,
        OP_H_E3,
        OP_MEAN
    } op_t;

endpackage

[design/temp_humidity_sensor_conditioner_core.sv]
// Temperature / humidity conditioner core: accumulation, bit-serial MAC,
// restoring divider, result register and APB-style register file.
// Depends on thsc_pkg.
//
// Usage
//   Input channel (in_valid / in_stall): one transfer carries action, sensor
//   and adc_code. A temperature transfer adds to the sensor's accumulator;
//   once samples_per_reading samples are in, a reading is produced. A
//   humidity transfer always produces a reading. Sensors at or above
//   SENSOR_COUNT are taken and dropped.
//   Output channel (out_valid / out_stall): a per-sensor result, followed,
//   for the last sensor, by the cross-sensor average (last marks the final
//   result of each input transfer).
//   Sequencing: an accumulating sample passes through ST_ACCUM and returns
//   to idle. A reading runs a chain of multiplies and then the divide; an
//   average adds one more divide. Every multiply consumes one multiplier
//   bit per cycle from a shift register, and the divide produces one
//   quotient bit per cycle. One input is worked at a time; in_stall is
//   high from the accepting edge until the last result of that input sits
//   in the output register.
//   A stalled output holds its result; the core runs on and waits only
//   when it has a new result and the output register is still full.
//   Reset clears registers to their defaults, accumulators and stored
//   readings to zero; the block is ready in the first cycle after reset.
module temp_humidity_sensor_conditioner_core #(
    parameter int SENSOR_COUNT = 2,
    parameter int ADC_BITS     = 10
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // register port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [3:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    // input channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              action,
    input  logic [thsc_pkg::TAG_W-1:0]        sensor,
    input  logic [thsc_pkg::ADC_W-1:0]        adc_code,
    // output channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [thsc_pkg::KIND_W-1:0]       kind,
    output logic [thsc_pkg::TAG_W-1:0]        sensor_tag,
    output logic signed [thsc_pkg::VAL_W-1:0] value_tenths,
    output logic                              last
);

    localparam int IDX_W = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
    localparam int TOT_W = thsc_pkg::VAL_W + IDX_W;
    localparam int FS    = (1 << ADC_BITS) - 1;
    localparam int HUM_OFS  = thsc_pkg::K_HUM_OFS * FS;
    localparam int HUM_SPAN = thsc_pkg::K_HUM_SPAN * FS;
    localparam logic [thsc_pkg::ADC_W-1:0] CODE_MASK = thsc_pkg::ADC_W'(FS);

    localparam int ACC_W = thsc_pkg::ACC_W;
    localparam int VAL_W = thsc_pkg::VAL_W;

    // ------------------------------------------------------------------
    // Register file
    // ------------------------------------------------------------------
    logic [12:0]                  supply_reg;
    logic [thsc_pkg::CNT_W-1:0]   spr_reg;
    logic [15:0]                  gain_reg;
    logic signed [15:0]           offset_reg;
    logic                         cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            supply_reg <= thsc_pkg::RST_SUPPLY;
            spr_reg    <= thsc_pkg::RST_SPR;
            gain_reg   <= thsc_pkg::RST_GAIN;
            offset_reg <= thsc_pkg::RST_OFFSET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                thsc_pkg::REG_SUPPLY: supply_reg <= pwdata[12:0];
                thsc_pkg::REG_SPR:    spr_reg    <= pwdata[thsc_pkg::CNT_W-1:0];
                thsc_pkg::REG_GAIN:   gain_reg   <= pwdata[15:0];
                thsc_pkg::REG_OFFSET: offset_reg <= $signed(pwdata[15:0]);
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            thsc_pkg::REG_SUPPLY: prdata = 32'(supply_reg);
            thsc_pkg::REG_SPR:    prdata = 32'(spr_reg);
            thsc_pkg::REG_GAIN:   prdata = 32'(gain_reg);
            thsc_pkg::REG_OFFSET: prdata = 32'(offset_reg);
        endcase
    end

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    thsc_pkg::state_t state_reg, state_next;
    thsc_pkg::op_t    op_reg, op_next;

    logic                         action_reg, action_next;
    logic [thsc_pkg::TAG_W-1:0]   sensor_reg, sensor_next;
    logic [thsc_pkg::ADC_W-1:0]   code_reg, code_next;

    // per-sensor accumulators and stored readings
    logic [thsc_pkg::SUM_W-1:0]   sum_arr_reg  [SENSOR_COUNT];
    logic [thsc_pkg::SUM_W-1:0]   sum_arr_next [SENSOR_COUNT];
    logic [thsc_pkg::CNT_W-1:0]   cnt_arr_reg  [SENSOR_COUNT];
    logic [thsc_pkg::CNT_W-1:0]   cnt_arr_next [SENSOR_COUNT];
    logic signed [VAL_W-1:0]      temp_arr_reg [SENSOR_COUNT];
    logic signed [VAL_W-1:0]      temp_arr_next[SENSOR_COUNT];
    logic signed [VAL_W-1:0]      hum_arr_reg  [SENSOR_COUNT];
    logic signed [VAL_W-1:0]      hum_arr_next [SENSOR_COUNT];
    // running totals of the stored readings, for the averages
    logic signed [TOT_W-1:0]      temp_tot_reg, temp_tot_next;
    logic signed [TOT_W-1:0]      hum_tot_reg, hum_tot_next;

    // MAC and divider datapath
    logic [thsc_pkg::SUM_W-1:0]   sum_reg, sum_next;
    logic [thsc_pkg::P_W-1:0]     p_reg, p_next;
    logic signed [ACC_W-1:0]      acc_reg, acc_next;
    logic signed [ACC_W-1:0]      a_reg, a_next;
    logic [thsc_pkg::MUL_B_W-1:0] b_reg, b_next;
    logic [thsc_pkg::DEN_W-1:0]   den_reg, den_next;
    logic                         comp_bad_reg, comp_bad_next;
    logic                         mean_reg, mean_next;
    logic [thsc_pkg::REM_W-1:0]   rem_reg, rem_next;
    logic [thsc_pkg::DV_W-1:0]    dv_reg, dv_next;
    logic [thsc_pkg::Q_W-1:0]     q_reg, q_next;
    logic                         neg_reg, neg_next;
    logic [thsc_pkg::IT_W-1:0]    it_reg, it_next;

    // output register
    logic                         out_valid_reg, out_valid_next;
    logic [thsc_pkg::KIND_W-1:0]  out_kind_reg, out_kind_next;
    logic [thsc_pkg::TAG_W-1:0]   out_tag_reg, out_tag_next;
    logic signed [VAL_W-1:0]      out_val_reg, out_val_next;
    logic                         out_last_reg, out_last_next;

    // helpers
    logic [IDX_W-1:0]             idx;
    logic                         sensor_ok;
    logic                         is_last;
    logic [thsc_pkg::CNT_W-1:0]   target;
    logic [thsc_pkg::SUM_W-1:0]   new_sum;
    logic [thsc_pkg::CNT_W-1:0]   new_cnt;
    logic [ACC_W-1:0]             acc_mag;
    logic [ACC_W-1:0]             p_wide;
    logic [15:0]                  off_mag;
    logic                         div_ge;
    logic signed [VAL_W-1:0]      div_val;
    logic signed [VAL_W-1:0]      result_val;
    logic signed [VAL_W-1:0]      old_val;

    assign idx       = sensor_reg[IDX_W-1:0];
    assign sensor_ok = {1'b0, sensor} < (thsc_pkg::TAG_W + 1)'(SENSOR_COUNT);
    assign is_last   = sensor_reg == thsc_pkg::TAG_W'(SENSOR_COUNT - 1);
    assign in_stall  = state_reg != thsc_pkg::ST_IDLE;

    // zero acts as one, anything above the limit as the limit
    always_comb
    begin
        priority if (spr_reg == '0)
            target = thsc_pkg::CNT_W'(1);
        else if (spr_reg > thsc_pkg::MAX_SAMPLES)
            target = thsc_pkg::MAX_SAMPLES;
        else
            target = spr_reg;
    end

    assign new_sum = sum_arr_reg[idx] + thsc_pkg::SUM_W'(code_reg);
    assign new_cnt = cnt_arr_reg[idx] + thsc_pkg::CNT_W'(1);
    assign acc_mag = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
    assign p_wide  = ACC_W'(p_reg);
    assign off_mag = offset_reg[15] ? 16'(-offset_reg) : 16'(offset_reg);
    assign div_ge  = thsc_pkg::DV_W'(rem_reg) >= dv_reg;
    assign old_val = action_reg ? hum_arr_reg[idx] : temp_arr_reg[idx];

    // quotient magnitude to saturated signed tenths
    always_comb
    begin
        priority if (q_reg[thsc_pkg::Q_W-1])
            div_val = neg_reg ? thsc_pkg::VAL_MIN : thsc_pkg::VAL_MAX;
        else if (!neg_reg)
            div_val = q_reg[VAL_W-1] ? thsc_pkg::VAL_MAX : $signed(q_reg[VAL_W-1:0]);
        else if (q_reg[VAL_W-1:0] > thsc_pkg::NEG_LIMIT)
            div_val = thsc_pkg::VAL_MIN;
        else
            div_val = $signed(-q_reg[VAL_W-1:0]);
    end

    // non-positive compensation divisor: saturate on the sign of the numerator
    assign result_val = comp_bad_reg
        ? (acc_reg[ACC_W-1] ? thsc_pkg::VAL_MIN : thsc_pkg::VAL_MAX)
        : div_val;

    // ------------------------------------------------------------------
    // Sequencer: next state and datapath
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        action_next    = action_reg;
        sensor_next    = sensor_reg;
        code_next      = code_reg;
        sum_arr_next   = sum_arr_reg;
        cnt_arr_next   = cnt_arr_reg;
        temp_arr_next  = temp_arr_reg;
        hum_arr_next   = hum_arr_reg;
        temp_tot_next  = temp_tot_reg;
        hum_tot_next   = hum_tot_reg;
        sum_next       = sum_reg;
        p_next         = p_reg;
        acc_next       = acc_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        den_next       = den_reg;
        comp_bad_next  = comp_bad_reg;
        mean_next      = mean_reg;
        rem_next       = rem_reg;
        dv_next        = dv_reg;
        q_next         = q_reg;
        neg_next       = neg_reg;
        it_next        = it_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_kind_next  = out_kind_reg;
        out_tag_next   = out_tag_reg;
        out_val_next   = out_val_reg;
        out_last_next  = out_last_reg;

        unique case (state_reg)
            thsc_pkg::ST_IDLE:
            begin
                if (in_valid && sensor_ok)
                begin
                    action_next = action;
                    sensor_next = sensor;
                    code_next   = adc_code & CODE_MASK;
                    mean_next   = 1'b0;
                    if (action == thsc_pkg::ACT_HUM)
                    begin
                        op_next    = thsc_pkg::OP_H_COMP;
                        state_next = thsc_pkg::ST_LOAD;
                    end
                    else
                    begin
                        state_next = thsc_pkg::ST_ACCUM;
                    end
                end
            end

            thsc_pkg::ST_ACCUM:
            begin
                if (new_cnt < target)
                begin
                    sum_arr_next[idx] = new_sum;
                    cnt_arr_next[idx] = new_cnt;
                    state_next        = thsc_pkg::ST_IDLE;
                end
                else
                begin
                    sum_arr_next[idx] = '0;
                    cnt_arr_next[idx] = '0;
                    sum_next          = new_sum;
                    // n * FS
                    p_next = (thsc_pkg::P_W'(new_cnt) << ADC_BITS) - thsc_pkg::P_W'(new_cnt);
                    op_next    = thsc_pkg::OP_T_DEN;
                    state_next = thsc_pkg::ST_LOAD;
                end
            end

            thsc_pkg::ST_LOAD:
            begin
                state_next = thsc_pkg::ST_MUL;
                unique case (op_reg)
                    // den = n*FS * 1638400
                    thsc_pkg::OP_T_DEN:
                    begin
                        comp_bad_next = 1'b0;
                        acc_next = '0;
                        a_next   = $signed(p_wide);
                        b_next   = thsc_pkg::MUL_B_W'(thsc_pkg::K_TEMP_DEN);
                    end
                    // sum * mV
                    thsc_pkg::OP_T_SV:
                    begin
                        den_next = thsc_pkg::DEN_W'(acc_reg);
                        acc_next = '0;
                        a_next   = $signed(ACC_W'(sum_reg));
                        b_next   = thsc_pkg::MUL_B_W'(supply_reg);
                    end
                    thsc_pkg::OP_T_X100:
                    begin
                        acc_next = '0;
                        a_next   = acc_reg;
                        b_next   = thsc_pkg::MUL_B_W'(thsc_pkg::K_CENTI);
                    end
                    // x = 100*sum*mV - 50000*n*FS
                    thsc_pkg::OP_T_X:
                    begin
                        a_next = $signed(-p_wide);
                        b_next = thsc_pkg::MUL_B_W'(thsc_pkg::K_HALF_DEG);
                    end
                    thsc_pkg::OP_T_G:
                    begin
                        acc_next = '0;
                        a_next   = acc_reg;
                        b_next   = thsc_pkg::MUL_B_W'(gain_reg);
                    end
                    // + offset * n*FS * 16384, sign moved onto the multiplicand
                    thsc_pkg::OP_T_OFF:
                    begin
                        a_next = offset_reg[15]
                            ? $signed(-(p_wide << thsc_pkg::GAIN_FRAC))
                            : $signed(p_wide << thsc_pkg::GAIN_FRAC);
                        b_next = thsc_pkg::MUL_B_W'(off_mag);
                    end
                    // comp = 1054600 - 216*T
                    thsc_pkg::OP_H_COMP:
                    begin
                        acc_next = ACC_W'(thsc_pkg::K_COMP_BASE);
                        a_next   = -ACC_W'(temp_arr_reg[idx]);
                        b_next   = thsc_pkg::MUL_B_W'(thsc_pkg::K_COMP_TEMP);
                    end
                    // den = comp * 62*FS
                    thsc_pkg::OP_H_DEN:
                    begin
                        comp_bad_next = acc_reg[ACC_W-1] || (acc_reg == '0);
                        acc_next = '0;
                        a_next   = acc_reg;
                        b_next   = thsc_pkg::MUL_B_W'(HUM_SPAN);
                    end
                    // 10000*code - 1600*FS
                    thsc_pkg::OP_H_DIFF:
                    begin
                        den_next = thsc_pkg::DEN_W'(acc_reg);
                        acc_next = -ACC_W'(HUM_OFS);
                        a_next   = $signed(ACC_W'(code_reg));
                        b_next   = thsc_pkg::MUL_B_W'(thsc_pkg::K_E4);
                    end
                    thsc_pkg::OP_H_E4:
                    begin
                        acc_next = '0;
                        a_next   = acc_reg;
                        b_next   = thsc_pkg::MUL_B_W'(thsc_pkg::K_E4);
                    end
                    thsc_pkg::OP_H_E3:
                    begin
                        acc_next = '0;
                        a_next   = acc_reg;
                        b_next   = thsc_pkg::MUL_B_W'(thsc_pkg::K_E3);
                    end
                    // average: running total over the sensor count
                    thsc_pkg::OP_MEAN:
                    begin
                        comp_bad_next = 1'b0;
                        acc_next = action_reg ? ACC_W'(hum_tot_reg) : ACC_W'(temp_tot_reg);
                        den_next = thsc_pkg::DEN_W'(SENSOR_COUNT);
                        a_next   = '0;
                        b_next   = '0;
                    end
                    default:
                    begin
                        state_next = thsc_pkg::ST_IDLE;
                    end
                endcase
            end

            // one multiplier bit per cycle
            thsc_pkg::ST_MUL:
            begin
                if (b_reg == '0)
                begin
                    state_next = thsc_pkg::ST_LOAD;
                    unique case (op_reg)
                        thsc_pkg::OP_T_DEN:  op_next = thsc_pkg::OP_T_SV;
                        thsc_pkg::OP_T_SV:   op_next = thsc_pkg::OP_T_X100;
                        thsc_pkg::OP_T_X100: op_next = thsc_pkg::OP_T_X;
                        thsc_pkg::OP_T_X:    op_next = thsc_pkg::OP_T_G;
                        thsc_pkg::OP_T_G:    op_next = thsc_pkg::OP_T_OFF;
                        thsc_pkg::OP_H_COMP: op_next = thsc_pkg::OP_H_DEN;
                        thsc_pkg::OP_H_DEN:  op_next = thsc_pkg::OP_H_DIFF;
                        thsc_pkg::OP_H_DIFF: op_next = thsc_pkg::OP_H_E4;
                        thsc_pkg::OP_H_E4:   op_next = thsc_pkg::OP_H_E3;
                        thsc_pkg::OP_T_OFF,
                        thsc_pkg::OP_H_E3,
                        thsc_pkg::OP_MEAN:   state_next = thsc_pkg::ST_DSET;
                        default:             state_next = thsc_pkg::ST_IDLE;
                    endcase
                end
                else
                begin
                    acc_next = acc_reg + (b_reg[0] ? a_reg : ACC_W'(0));
                    a_next   = a_reg <<< 1;
                    b_next   = b_reg >> 1;
                end
            end

            // |num| + den/2, divisor aligned to the overflow bit
            thsc_pkg::ST_DSET:
            begin
                neg_next   = acc_reg[ACC_W-1];
                rem_next   = thsc_pkg::REM_W'(acc_mag) + thsc_pkg::REM_W'(den_reg >> 1);
                dv_next    = thsc_pkg::DV_W'(den_reg) << (thsc_pkg::Q_W - 1);
                q_next     = '0;
                it_next    = '0;
                state_next = thsc_pkg::ST_DIV;
            end

            // restoring divide, one quotient bit per cycle
            thsc_pkg::ST_DIV:
            begin
                if (div_ge)
                    rem_next = rem_reg - dv_reg[thsc_pkg::REM_W-1:0];
                q_next  = {q_reg[thsc_pkg::Q_W-2:0], div_ge};
                dv_next = dv_reg >> 1;
                it_next = it_reg + thsc_pkg::IT_W'(1);
                if (it_reg == thsc_pkg::IT_W'(thsc_pkg::Q_W - 1))
                    state_next = thsc_pkg::ST_EMIT;
            end

            thsc_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_val_next   = result_val;
                    if (!mean_reg)
                    begin
                        out_kind_next = action_reg ? thsc_pkg::KIND_HUM : thsc_pkg::KIND_TEMP;
                        out_tag_next  = sensor_reg;
                        out_last_next = !is_last;
                        if (action_reg)
                        begin
                            hum_arr_next[idx] = result_val;
                            hum_tot_next = hum_tot_reg + TOT_W'(result_val) - TOT_W'(old_val);
                        end
                        else
                        begin
                            temp_arr_next[idx] = result_val;
                            temp_tot_next = temp_tot_reg + TOT_W'(result_val)
                                          - TOT_W'(old_val);
                        end
                        if (is_last)
                        begin
                            mean_next  = 1'b1;
                            op_next    = thsc_pkg::OP_MEAN;
                            state_next = thsc_pkg::ST_LOAD;
                        end
                        else
                        begin
                            state_next = thsc_pkg::ST_IDLE;
                        end
                    end
                    else
                    begin
                        out_kind_next = action_reg ? thsc_pkg::KIND_HUM_AVG
                                                   : thsc_pkg::KIND_TEMP_AVG;
                        out_tag_next  = '0;
                        out_last_next = 1'b1;
                        mean_next     = 1'b0;
                        state_next    = thsc_pkg::ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = thsc_pkg::ST_IDLE;
            end
        endcase
    end

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= thsc_pkg::ST_IDLE;
            op_reg        <= thsc_pkg::OP_T_DEN;
            mean_reg      <= 1'b0;
            comp_bad_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            temp_tot_reg  <= '0;
            hum_tot_reg   <= '0;
            for (int i = 0; i < SENSOR_COUNT; i++)
            begin
                sum_arr_reg[i]  <= '0;
                cnt_arr_reg[i]  <= '0;
                temp_arr_reg[i] <= '0;
                hum_arr_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            mean_reg      <= mean_next;
            comp_bad_reg  <= comp_bad_next;
            out_valid_reg <= out_valid_next;
            temp_tot_reg  <= temp_tot_next;
            hum_tot_reg   <= hum_tot_next;
            sum_arr_reg   <= sum_arr_next;
            cnt_arr_reg   <= cnt_arr_next;
            temp_arr_reg  <= temp_arr_next;
            hum_arr_reg   <= hum_arr_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        action_reg   <= action_next;
        sensor_reg   <= sensor_next;
        code_reg     <= code_next;
        sum_reg      <= sum_next;
        p_reg        <= p_next;
        acc_reg      <= acc_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        den_reg      <= den_next;
        rem_reg      <= rem_next;
        dv_reg       <= dv_next;
        q_reg        <= q_next;
        neg_reg      <= neg_next;
        it_reg       <= it_next;
        out_kind_reg <= out_kind_next;
        out_tag_reg  <= out_tag_next;
        out_val_reg  <= out_val_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid    = out_valid_reg;
    assign kind         = out_kind_reg;
    assign sensor_tag   = out_tag_reg;
    assign value_tenths = out_val_reg;
    assign last         = out_last_reg;

endmodule

[design/thsc_checker.sv]
// Port-level checks for the temperature / humidity conditioner core,
// bound to the top level. Depends on thsc_pkg.
module thsc_checker #(
    parameter int SENSOR_COUNT = 2
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_stall,
    input logic [thsc_pkg::TAG_W-1:0]        sensor,
    input logic                              out_valid,
    input logic                              out_stall,
    input logic [thsc_pkg::KIND_W-1:0]       kind,
    input logic [thsc_pkg::TAG_W-1:0]        sensor_tag,
    input logic signed [thsc_pkg::VAL_W-1:0] value_tenths,
    input logic                              last
);

    // a transfer for a real sensor occupies the core
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall
            && ({1'b0, sensor} < (thsc_pkg::TAG_W + 1)'(SENSOR_COUNT)))
        |=> in_stall)
        else $error("core took a transfer without going busy");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall)
        |=> (out_valid && $stable(kind) && $stable(sensor_tag)
             && $stable(value_tenths) && $stable(last)))
        else $error("stalled result changed");

    // averages close the burst and carry no sensor tag
    a_avg_form: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (kind == thsc_pkg::KIND_TEMP_AVG || kind == thsc_pkg::KIND_HUM_AVG))
        |-> (last && sensor_tag == '0))
        else $error("average result malformed");

    // a per-sensor result is final unless an average follows it
    a_sensor_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (kind == thsc_pkg::KIND_TEMP || kind == thsc_pkg::KIND_HUM))
        |-> ((last == (sensor_tag != thsc_pkg::TAG_W'(SENSOR_COUNT - 1)))
             && ({1'b0, sensor_tag} < (thsc_pkg::TAG_W + 1)'(SENSOR_COUNT))))
        else $error("per-sensor result tag or last flag wrong");

endmodule

bind temp_humidity_sensor_conditioner_core thsc_checker #(
    .SENSOR_COUNT(SENSOR_COUNT)
) u_thsc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sensor       (sensor),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .sensor_tag   (sensor_tag),
    .value_tenths (value_tenths),
    .last         (last)
);
